>>> hdl/avr_pkg.sv
package avr_pkg;

    typedef enum logic [4:0] {
        K_NOP   = 5'd0,
        K_MOVW  = 5'd1,
        K_MULS  = 5'd2,
        K_MULSU = 5'd3,
        K_FMUL  = 5'd4,
        K_LDI   = 5'd5,
        K_RJMP  = 5'd6,
        K_MOV   = 5'd7,
        K_DEC   = 5'd8,
        K_PUSH  = 5'd9,
        K_POP   = 5'd10,
        K_OUT   = 5'd11,
        K_EOR   = 5'd12,
        K_LDX   = 5'd13,
        K_LDY   = 5'd14,
        K_LDZ   = 5'd15,
        K_BRNE  = 5'd16,
        K_RCALL = 5'd17,
        K_RET   = 5'd18,
        K_CPI   = 5'd19,
        K_SES   = 5'd20,
        K_SET   = 5'd21,
        K_SEV   = 5'd22,
        K_SEZ   = 5'd23,
        K_SEH   = 5'd24,
        K_SEC   = 5'd25,
        K_SEI   = 5'd26,
        K_SEN   = 5'd27,
        K_BCLR  = 5'd28
    } kind_t;

    localparam int FLAG_C = 0;
    localparam int FLAG_Z = 1;
    localparam int FLAG_N = 2;
    localparam int FLAG_V = 3;
    localparam int FLAG_S = 4;
    localparam int FLAG_H = 5;
    localparam int FLAG_T = 6;
    localparam int FLAG_I = 7;

    typedef struct packed {
        logic [15:0] pc_next;
        logic [7:0]  sreg_out;
        logic        reg_write_valid;
        logic [4:0]  reg_write_index;
        logic [7:0]  reg_write_value;
        logic        mem_write_valid;
        logic [11:0] mem_write_addr;
        logic [7:0]  mem_write_value;
        logic        stack_error;
        logic        unimplemented;
    } result_t;

endpackage

>>> hdl/avr_instruction_subset_execute.sv
// Channel | Ports                       | Payload
// s_      | s_tvalid s_tready s_tdata   | instr_kind[4:0] opcode_word[20:5]
// m_      | m_tvalid m_tready m_tdata   | result fields, see m_tdata
// The accepting edge registers the data store and return stack reads; the
// execute step writes back and loads m_tdata once the result register is free.
// s_tready is low while an instruction sits in the read stage, so no new one is
// taken until it has executed, and accesses to the same entry never overlap.
// Data store reset is a clearing pass over every entry after aresetn, with
// s_tready low. A full result register that is not taken holds the read stage.
module avr_instruction_subset_execute #(
    parameter int DATA_DEPTH  = 4096,
    parameter int STACK_DEPTH = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,  // instr_kind[4:0], opcode_word[20:5], zero
    output logic        m_tvalid,
    input  logic        m_tready,
    // pc_next[15:0] sreg_out[23:16] reg_write_valid[24] reg_write_index[29:25]
    // reg_write_value[37:30] mem_write_valid[38] mem_write_addr[50:39]
    // mem_write_value[58:51] stack_error[59] unimplemented[60], zero to 63
    output logic [63:0] m_tdata
);
    localparam int DW = $clog2(DATA_DEPTH);
    localparam int SW = $clog2(STACK_DEPTH);

    logic [7:0] rf_reg [32];
    logic [7:0] dmem [DATA_DEPTH];
    logic [7:0] smem [STACK_DEPTH];

    logic [7:0]  sreg_reg;
    logic [15:0] pc_reg;
    logic [SW:0] fill_reg;
    logic [DW:0] clr_reg;
    logic        clearing;

    // stage 1 holds the instruction while the memories are read
    logic        v1_reg;
    logic [4:0]  k1_reg;
    logic [15:0] w1_reg;
    logic [7:0]  dm_q, s0_q, s1_q;

    logic             m_v_reg;
    avr_pkg::result_t m_reg;

    assign clearing = !clr_reg[DW];
    logic adv;
    assign adv = !m_v_reg || m_tready;
    assign s_tready = !clearing && adv && !v1_reg;

    logic [4:0]  ks;
    logic [15:0] ws;
    assign ks = s_tdata[4:0];
    assign ws = s_tdata[20:5];

    // read addresses from stage-0 inputs; the register file is current since
    // no instruction sits in stage 1 when one is accepted
    logic [4:0]  pb;
    logic [15:0] ptr;
    always_comb begin
        pb = 5'd26;
        if (ks == avr_pkg::K_LDY) pb = 5'd28;
        if (ks == avr_pkg::K_LDZ) pb = 5'd30;
        ptr = {rf_reg[pb + 5'd1], rf_reg[pb]};
    end

    logic    do2;
    avr_pkg::result_t r;
    logic [7:0]  sr;
    logic [15:0] nx;
    logic [SW:0] fl;
    logic        sp_we;
    logic [SW-1:0] sp_wa;
    logic [7:0]  sp_wd;
    logic        rf_we, rf_we2;
    logic [4:0]  rf_wa;
    logic [7:0]  rf_wd, rf_wd2;
    logic        dm_we;
    logic [DW-1:0] dm_wa;
    logic [7:0]  dm_wd;

    logic [4:0] d5, r5;
    logic [7:0] k8, rd, rr, res;
    logic [15:0] rj, br;
    logic [4:0] ma, mb;
    logic d7, k7, r7, d3, k3, r3, ov;

    assign do2 = v1_reg && adv;

    always_comb begin
        d5 = w1_reg[8:4];
        r5 = {w1_reg[9], w1_reg[3:0]};
        k8 = {w1_reg[11:8], w1_reg[3:0]};
        rd = rf_reg[d5];
        rr = rf_reg[r5];
        ma = {w1_reg[7:4], 1'b0};
        mb = {w1_reg[3:0], 1'b0};
        rj = pc_reg + {{4{w1_reg[11]}}, w1_reg[11:0]} + 16'd1;
        br = pc_reg + {{9{w1_reg[9]}}, w1_reg[9:3]} + 16'd1;
        sr = sreg_reg;
        nx = pc_reg + 16'd1;
        fl = fill_reg;
        r = '0;
        res = '0;
        d7 = 1'b0; k7 = 1'b0; r7 = 1'b0; d3 = 1'b0; k3 = 1'b0; r3 = 1'b0; ov = 1'b0;
        sp_we = 1'b0; sp_wa = '0; sp_wd = '0;
        rf_we = 1'b0; rf_wa = '0; rf_wd = '0; rf_we2 = 1'b0; rf_wd2 = '0;
        dm_we = 1'b0; dm_wa = '0; dm_wd = '0;
        case (k1_reg)
            avr_pkg::K_MOVW: begin
                rf_we = 1'b1; rf_wa = ma; rf_wd = rf_reg[mb];
                rf_we2 = 1'b1; rf_wd2 = rf_reg[mb + 5'd1];
            end
            avr_pkg::K_MULS, avr_pkg::K_MULSU, avr_pkg::K_FMUL: r.unimplemented = 1'b1;
            avr_pkg::K_LDI: begin
                rf_we = 1'b1; rf_wa = {1'b1, w1_reg[7:4]}; rf_wd = k8;
            end
            avr_pkg::K_RJMP: nx = rj;
            avr_pkg::K_MOV: begin rf_we = 1'b1; rf_wa = d5; rf_wd = rr; end
            avr_pkg::K_DEC: begin
                res = rd - 8'd1;
                sr[avr_pkg::FLAG_V] = (res == 8'h7f);
                sr[avr_pkg::FLAG_N] = res[7];
                sr[avr_pkg::FLAG_S] = (res == 8'h7f) ^ res[7];
                sr[avr_pkg::FLAG_Z] = (res == 8'h00);
                rf_we = 1'b1; rf_wa = d5; rf_wd = res;
            end
            avr_pkg::K_PUSH: begin
                if (fill_reg >= (SW+1)'(STACK_DEPTH)) r.stack_error = 1'b1;
                else begin
                    sp_we = 1'b1; sp_wa = fill_reg[SW-1:0]; sp_wd = rd;
                    fl = fill_reg + 1'b1;
                end
            end
            avr_pkg::K_POP: begin
                if (fill_reg == '0) begin r.stack_error = 1'b1; res = '0; end
                else begin res = s0_q; fl = fill_reg - 1'b1; end
                rf_we = 1'b1; rf_wa = d5; rf_wd = res;
            end
            avr_pkg::K_OUT: begin
                r.mem_write_valid = 1'b1;
                r.mem_write_addr = {6'd0, w1_reg[10:9], w1_reg[3:0]};
                r.mem_write_value = rd;
                dm_we = 1'b1; dm_wa = DW'({w1_reg[10:9], w1_reg[3:0]}); dm_wd = rd;
            end
            avr_pkg::K_EOR: begin
                res = rd ^ rr;
                sr[avr_pkg::FLAG_V] = 1'b0;
                sr[avr_pkg::FLAG_N] = res[7];
                sr[avr_pkg::FLAG_S] = res[7];
                sr[avr_pkg::FLAG_Z] = (res == 8'h00);
                rf_we = 1'b1; rf_wa = d5; rf_wd = res;
            end
            avr_pkg::K_LDX, avr_pkg::K_LDY, avr_pkg::K_LDZ: begin
                rf_we = 1'b1; rf_wa = d5; rf_wd = dm_q;
            end
            avr_pkg::K_BRNE: if (!sreg_reg[avr_pkg::FLAG_Z]) nx = br;
            avr_pkg::K_RCALL: begin
                // low byte then high byte; a full stack refuses each byte
                if (fill_reg >= (SW+1)'(STACK_DEPTH)) r.stack_error = 1'b1;
                else if (fill_reg == (SW+1)'(STACK_DEPTH - 1)) begin
                    r.stack_error = 1'b1;
                    sp_we = 1'b1; sp_wa = fill_reg[SW-1:0]; sp_wd = nx[7:0];
                    fl = fill_reg + 1'b1;
                end else begin
                    sp_we = 1'b1; sp_wa = fill_reg[SW-1:0]; sp_wd = nx[7:0];
                    fl = fill_reg + (SW+1)'(2);
                end
                nx = rj;
            end
            avr_pkg::K_RET: begin
                if (fill_reg >= (SW+1)'(2)) begin
                    nx = {s0_q, s1_q}; fl = fill_reg - (SW+1)'(2);
                end else if (fill_reg == (SW+1)'(1)) begin
                    nx = {s0_q, 8'd0}; fl = '0; r.stack_error = 1'b1;
                end else begin
                    nx = 16'd0; r.stack_error = 1'b1;
                end
            end
            avr_pkg::K_CPI: begin
                rd = rf_reg[{1'b1, w1_reg[7:4]}];
                res = rd - k8;
                d7 = rd[7]; k7 = k8[7]; r7 = res[7];
                d3 = rd[3]; k3 = k8[3]; r3 = res[3];
                ov = (d7 & !k7 & !r7) | (!d7 & k7 & r7);
                sr[avr_pkg::FLAG_C] = (!d7 & k7) | (k7 & r7) | (r7 & !d7);
                sr[avr_pkg::FLAG_V] = ov;
                sr[avr_pkg::FLAG_H] = (!d3 & k3) | (k3 & r3) | (r3 & !d3);
                sr[avr_pkg::FLAG_N] = r7;
                sr[avr_pkg::FLAG_S] = r7 ^ ov;
                sr[avr_pkg::FLAG_Z] = (res == 8'h00);
            end
            avr_pkg::K_SES: sr[avr_pkg::FLAG_S] = 1'b1;
            avr_pkg::K_SET: sr[avr_pkg::FLAG_T] = 1'b1;
            avr_pkg::K_SEV: sr[avr_pkg::FLAG_V] = 1'b1;
            avr_pkg::K_SEZ: sr[avr_pkg::FLAG_Z] = 1'b1;
            avr_pkg::K_SEH: sr[avr_pkg::FLAG_H] = 1'b1;
            avr_pkg::K_SEC: sr[avr_pkg::FLAG_C] = 1'b1;
            avr_pkg::K_SEI: sr[avr_pkg::FLAG_I] = 1'b1;
            avr_pkg::K_SEN: sr[avr_pkg::FLAG_N] = 1'b1;
            avr_pkg::K_BCLR: sr[w1_reg[6:4]] = 1'b0;
            default: ;
        endcase
        r.pc_next = nx;
        r.sreg_out = sr;
        r.reg_write_valid = rf_we;
        r.reg_write_index = rf_we ? rf_wa : 5'd0;
        r.reg_write_value = rf_we ? rf_wd : 8'd0;
    end

    // rcall's high byte goes in the entry after the low byte
    logic          sp_we2;
    logic [15:0]   pc_inc;
    assign sp_we2 = (k1_reg == avr_pkg::K_RCALL) && (fill_reg < (SW+1)'(STACK_DEPTH - 1));
    assign pc_inc = pc_reg + 16'd1;

    logic s_fire;
    assign s_fire = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            m_v_reg <= 1'b0;
            sreg_reg <= '0;
            pc_reg <= '0;
            fill_reg <= '0;
            clr_reg <= '0;
            for (int i = 0; i < 32; i++) rf_reg[i] <= '0;
        end else begin
            if (clearing) clr_reg <= clr_reg + 1'b1;
            if (adv) begin
                m_v_reg <= v1_reg;
                if (v1_reg) m_reg <= r;
                v1_reg <= s_fire;
            end else if (m_tready) begin
                m_v_reg <= 1'b0;
            end
            if (do2) begin
                sreg_reg <= sr;
                pc_reg <= nx;
                fill_reg <= fl;
                if (rf_we) rf_reg[rf_wa] <= rf_wd;
                if (rf_we2) rf_reg[rf_wa + 5'd1] <= rf_wd2;
            end
            if (s_fire) begin
                k1_reg <= ks;
                w1_reg <= ws;
            end
        end
    end

    // reads happen only while stage 1 is empty, so every earlier write has landed
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            dm_q <= dmem[ptr[DW-1:0]];
            s0_q <= smem[SW'(fill_reg - 1'b1)];
            s1_q <= smem[SW'(fill_reg - (SW+1)'(2))];
        end
        if (clearing) dmem[clr_reg[DW-1:0]] <= '0;
        else if (do2 && dm_we) dmem[dm_wa] <= dm_wd;
        if (do2 && sp_we) smem[sp_wa] <= sp_wd;
        if (do2 && sp_we2) smem[SW'(fill_reg + 1'b1)] <= pc_inc[15:8];
    end

    assign m_tvalid = m_v_reg;
    assign m_tdata = {3'd0, m_reg.unimplemented, m_reg.stack_error, m_reg.mem_write_value,
                      m_reg.mem_write_addr, m_reg.mem_write_valid, m_reg.reg_write_value,
                      m_reg.reg_write_index, m_reg.reg_write_valid, m_reg.sreg_out,
                      m_reg.pc_next};
endmodule
